FILE: rtl/estm_pkg.sv
// shared types, constants and fixed-point helpers for the transform matrix builder
`default_nettype none
package estm_pkg;

    typedef logic [32:0] term_t;

    typedef struct packed {
        term_t [2:0][2:0]  rot;
        logic  [2:0][31:0] scl;
        logic  [2:0][31:0] trn;
        logic              zs;
    } item_t;

    typedef struct packed {
        logic start;
        logic normal;
    } lane_ctl_t;

    localparam logic signed [33:0] INV_TWO_PI = 34'sd683565276;
    localparam logic signed [33:0] ONE_Q30    = 34'sd1073741824;
    localparam logic signed [67:0] HALF_Q30   = 68'sd536870912;
    localparam logic signed [31:0] SAT_MAX    = 32'sh7fffffff;
    localparam logic signed [31:0] SAT_MIN    = 32'sh80000000;
    localparam logic [16:0]        W_ONE      = 17'd65536;
    localparam logic [2:0]         TRN_COL    = 3'd3;
    localparam logic [2:0]         NRM_COL0   = 3'd4;
    localparam logic [2:0]         LAST_COL   = 3'd6;
    localparam logic [1:0]         FIFO_DEPTH = 2'd2;
    localparam logic [5:0]         DIV_STEPS  = 6'd35;

    function automatic logic signed [33:0] horner_coef(input logic [2:0] k);
        logic signed [33:0] c;
        case (k)
            3'd0:    c = 34'sd3864;
            3'd1:    c = 34'sd172272;
            3'd2:    c = 34'sd5026995;
            3'd3:    c = 34'sd85569306;
            3'd4:    c = 34'sd693598668;
            default: c = 34'sd1686629713;
        endcase
        return c;
    endfunction

    function automatic logic signed [67:0] round_q30(input logic signed [67:0] p);
        return (p + HALF_Q30) >>> 30;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647)
        begin
            r = SAT_MAX;
        end
        else if (v < -68'sd2147483648)
        begin
            r = SAT_MIN;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/euler_scale_transform_matrix.sv
// top level of the model and normal matrix builder
//
// Takes one object (translation, Y-X-Z angles in radians and scales, all signed Q16.16)
// and returns seven column beats: model columns 0..3, then normal columns 0..2.
// The front end works out phases, six sine/cosine values and nine rotation terms on one
// shared multiplier with a registered product, 59 products per object. The back end runs
// concurrently on the previous object through a two-entry queue: a rounded scale product
// per scaled model column, a pass-through for the translation column and a 35-step divider
// per normal column, in each of three row lanes (the divider is skipped on a zero scale);
// the back end sets the sustained rate. A new object is taken as soon as the input buffer
// is free.
`default_nettype none
module euler_scale_transform_matrix (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] translate_x,
    input  logic signed [31:0] translate_y,
    input  logic signed [31:0] translate_z,
    input  logic signed [31:0] angle_x,
    input  logic signed [31:0] angle_y,
    input  logic signed [31:0] angle_z,
    input  logic signed [31:0] scale_x,
    input  logic signed [31:0] scale_y,
    input  logic signed [31:0] scale_z,
    output logic               empty,
    input  logic               pop,
    output logic               matrix_id,
    output logic [1:0]         column_index,
    output logic signed [31:0] elem_x,
    output logic signed [31:0] elem_y,
    output logic signed [31:0] elem_z,
    output logic [16:0]        elem_w,
    output logic               zero_scale,
    output logic               last_column
);
    import estm_pkg::*;

    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;
    item_t q_wr_item;
    item_t q_head;

    estm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .translate_x (translate_x),
        .translate_y (translate_y),
        .translate_z (translate_z),
        .angle_x     (angle_x),
        .angle_y     (angle_y),
        .angle_z     (angle_z),
        .scale_x     (scale_x),
        .scale_y     (scale_y),
        .scale_z     (scale_z),
        .fifo_full   (q_full),
        .fifo_push   (q_push),
        .fifo_item   (q_wr_item)
    );

    estm_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_item (q_wr_item),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .head    (q_head)
    );

    estm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .fifo_empty   (q_empty),
        .head         (q_head),
        .fifo_pop     (q_pop),
        .empty        (empty),
        .pop          (pop),
        .matrix_id    (matrix_id),
        .column_index (column_index),
        .elem_x       (elem_x),
        .elem_y       (elem_y),
        .elem_z       (elem_z),
        .elem_w       (elem_w),
        .zero_scale   (zero_scale),
        .last_column  (last_column)
    );

    a_last_is_normal_col2: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last_column) |-> (matrix_id && column_index == 2'd2))
        else $error("last beat is not normal column 2");

    a_w_only_on_trn: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && elem_w != 17'd0) |-> (!matrix_id && column_index == 2'd3 && elem_w == W_ONE))
        else $error("row 3 set outside the translation column");

    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("term queue written while full");

endmodule
`default_nettype wire

FILE: rtl/estm_lane.sv
// one matrix row lane: rounded scale product for model columns, divider for normal columns
`default_nettype none
module estm_lane (
    input  logic               clk,
    input  logic               rst_n,
    input  estm_pkg::lane_ctl_t ctl,
    input  logic [32:0]        term,
    input  logic [31:0]        scale,
    output logic               done,
    output logic [31:0]        result
);
    import estm_pkg::*;

    typedef enum logic [2:0] {LN_IDLE, LN_MUL, LN_DIV, LN_FIX, LN_DONE} lstate_t;

    lstate_t            state_reg;
    logic signed [67:0] prod_reg;
    logic [34:0]        num_reg;
    logic [32:0]        rem_reg;
    logic [31:0]        den_reg;
    logic [5:0]         cnt_reg;
    logic               neg_reg;
    logic [31:0]        res_reg;

    logic signed [32:0] ts;
    logic signed [31:0] ss;
    logic signed [34:0] n4;
    logic [34:0]        an;
    logic [31:0]        as_mag;
    logic [34:0]        numer;
    logic [33:0]        sh;
    logic [33:0]        diff;
    logic               ge;

    assign ts     = $signed(term);
    assign ss     = $signed(scale);
    assign n4     = {ts, 2'b00};
    assign an     = n4[34] ? 35'(-n4) : 35'(n4);
    assign as_mag = ss[31] ? 32'(-{ss[31], ss}) : 32'(ss);
    assign numer  = an + {4'b0000, as_mag[31:1]};
    assign sh     = {rem_reg, num_reg[34]};
    assign diff   = sh - {2'b00, den_reg};
    assign ge     = (sh >= {2'b00, den_reg});

    assign done   = (state_reg == LN_DONE);
    assign result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LN_IDLE;
        end
        else
        begin
            unique case (state_reg)
                LN_IDLE:
                begin
                    if (ctl.start)
                    begin
                        if (!ctl.normal)
                        begin
                            prod_reg  <= ss * ts;
                            state_reg <= LN_MUL;
                        end
                        else if (ss == 32'sd0)
                        begin
                            if (ts > 33'sd0)
                            begin
                                res_reg <= SAT_MAX;
                            end
                            else if (ts < 33'sd0)
                            begin
                                res_reg <= SAT_MIN;
                            end
                            else
                            begin
                                res_reg <= 32'd0;
                            end
                            state_reg <= LN_DONE;
                        end
                        else
                        begin
                            num_reg   <= numer;
                            rem_reg   <= 33'd0;
                            den_reg   <= as_mag;
                            cnt_reg   <= DIV_STEPS;
                            neg_reg   <= ts[32] ^ ss[31];
                            state_reg <= LN_DIV;
                        end
                    end
                end
                LN_MUL:
                begin
                    res_reg   <= sat32(round_q30(prod_reg));
                    state_reg <= LN_DONE;
                end
                LN_DIV:
                begin
                    rem_reg <= ge ? diff[32:0] : sh[32:0];
                    num_reg <= {num_reg[33:0], ge};
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                    begin
                        state_reg <= LN_FIX;
                    end
                end
                LN_FIX:
                begin
                    if (neg_reg)
                    begin
                        res_reg <= (num_reg > 35'd2147483648) ? SAT_MIN : 32'(-num_reg);
                    end
                    else
                    begin
                        res_reg <= (num_reg > 35'd2147483647) ? SAT_MAX : num_reg[31:0];
                    end
                    state_reg <= LN_DONE;
                end
                LN_DONE:
                begin
                    state_reg <= LN_IDLE;
                end
                default:
                begin
                    state_reg <= LN_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/estm_front.sv
// front end: input buffer, angle phases, sine/cosine and rotation terms on one shared multiplier
`default_nettype none
module estm_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] translate_x,
    input  logic signed [31:0] translate_y,
    input  logic signed [31:0] translate_z,
    input  logic signed [31:0] angle_x,
    input  logic signed [31:0] angle_y,
    input  logic signed [31:0] angle_z,
    input  logic signed [31:0] scale_x,
    input  logic signed [31:0] scale_y,
    input  logic signed [31:0] scale_z,
    input  logic               fifo_full,
    output logic               fifo_push,
    output estm_pkg::item_t    fifo_item
);
    import estm_pkg::*;

    typedef enum logic [2:0] {F_IDLE, F_PHASE, F_SINE, F_ROT, F_PUSH} fstate_t;

    localparam logic [2:0] S1 = 3'd0;
    localparam logic [2:0] C1 = 3'd1;
    localparam logic [2:0] S2 = 3'd2;
    localparam logic [2:0] C2 = 3'd3;
    localparam logic [2:0] S3 = 3'd4;
    localparam logic [2:0] C3 = 3'd5;

    fstate_t            state_reg;
    logic               buf_valid_reg;
    logic signed [31:0] buf_ang_reg [3];
    logic signed [31:0] buf_trn_reg [3];
    logic signed [31:0] buf_scl_reg [3];
    logic signed [31:0] ang_reg [3];
    logic [31:0]        ph_reg [3];
    logic [3:0]         step_reg;
    logic [2:0]         ev_reg;
    logic               half_reg;
    logic [30:0]        x2_reg;
    logic signed [33:0] p_reg;
    logic signed [31:0] sc_reg [6];
    logic signed [31:0] s1s2_reg;
    logic signed [31:0] c1s2_reg;
    logic signed [67:0] prod_reg;
    item_t              item_reg;

    logic [31:0]        sph;
    logic [30:0]        xq;
    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [67:0] shr;
    logic signed [67:0] rnd;
    logic signed [32:0] r;
    logic signed [33:0] qs;
    logic signed [31:0] qlim;
    logic signed [31:0] sv;

    assign sph  = ph_reg[ev_reg[2:1]] + ({ev_reg[0], 31'd0} >> 1);
    assign xq   = sph[30] ? (31'h40000000 - {1'b0, sph[29:0]}) : {1'b0, sph[29:0]};
    assign shr  = prod_reg >>> 30;
    assign rnd  = round_q30(prod_reg);
    assign r    = rnd[32:0];
    assign qs   = shr[33:0];
    assign qlim = (qs > ONE_Q30) ? 32'sh40000000 : qs[31:0];
    assign sv   = sph[31] ? -qlim : qlim;

    assign full      = buf_valid_reg;
    assign fifo_push = (state_reg == F_PUSH) && !fifo_full;
    assign fifo_item = item_reg;

    always_comb
    begin
        mul_a = 34'sd0;
        mul_b = 34'sd0;
        unique case (state_reg)
            F_PHASE:
            begin
                mul_a = 34'(ang_reg[step_reg[1:0]]);
                mul_b = INV_TWO_PI;
            end
            F_SINE:
            begin
                if (step_reg == 4'd0)
                begin
                    mul_a = {3'b000, xq};
                    mul_b = {3'b000, xq};
                end
                else if (step_reg == 4'd6)
                begin
                    mul_a = {3'b000, xq};
                    mul_b = p_reg;
                end
                else
                begin
                    mul_a = {3'b000, x2_reg};
                    mul_b = p_reg;
                end
            end
            F_ROT:
            begin
                case (step_reg)
                    4'd0:    begin mul_a = 34'(sc_reg[S1]); mul_b = 34'(sc_reg[S2]); end
                    4'd1:    begin mul_a = 34'(sc_reg[C1]); mul_b = 34'(sc_reg[S2]); end
                    4'd2:    begin mul_a = 34'(sc_reg[C1]); mul_b = 34'(sc_reg[C3]); end
                    4'd3:    begin mul_a = 34'(s1s2_reg);   mul_b = 34'(sc_reg[S3]); end
                    4'd4:    begin mul_a = 34'(sc_reg[C2]); mul_b = 34'(sc_reg[S3]); end
                    4'd5:    begin mul_a = 34'(c1s2_reg);   mul_b = 34'(sc_reg[S3]); end
                    4'd6:    begin mul_a = 34'(sc_reg[C3]); mul_b = 34'(sc_reg[S1]); end
                    4'd7:    begin mul_a = 34'(s1s2_reg);   mul_b = 34'(sc_reg[C3]); end
                    4'd8:    begin mul_a = 34'(sc_reg[C1]); mul_b = 34'(sc_reg[S3]); end
                    4'd9:    begin mul_a = 34'(sc_reg[C2]); mul_b = 34'(sc_reg[C3]); end
                    4'd10:   begin mul_a = 34'(c1s2_reg);   mul_b = 34'(sc_reg[C3]); end
                    4'd11:   begin mul_a = 34'(sc_reg[S1]); mul_b = 34'(sc_reg[S3]); end
                    4'd12:   begin mul_a = 34'(sc_reg[C2]); mul_b = 34'(sc_reg[S1]); end
                    default: begin mul_a = 34'(sc_reg[C1]); mul_b = 34'(sc_reg[C2]); end
                endcase
            end
            F_IDLE, F_PUSH:
            begin
                mul_a = 34'sd0;
                mul_b = 34'sd0;
            end
            default:
            begin
                mul_a = 34'sd0;
                mul_b = 34'sd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            buf_valid_reg <= 1'b0;
            step_reg      <= 4'd0;
            ev_reg        <= 3'd0;
            half_reg      <= 1'b0;
        end
        else
        begin
            prod_reg <= mul_a * mul_b;
            if (push && !buf_valid_reg)
            begin
                buf_valid_reg  <= 1'b1;
                buf_ang_reg[0] <= angle_y;
                buf_ang_reg[1] <= angle_x;
                buf_ang_reg[2] <= angle_z;
                buf_trn_reg[0] <= translate_x;
                buf_trn_reg[1] <= translate_y;
                buf_trn_reg[2] <= translate_z;
                buf_scl_reg[0] <= scale_x;
                buf_scl_reg[1] <= scale_y;
                buf_scl_reg[2] <= scale_z;
            end
            unique case (state_reg)
                F_IDLE:
                begin
                    if (buf_valid_reg)
                    begin
                        buf_valid_reg   <= 1'b0;
                        ang_reg         <= buf_ang_reg;
                        item_reg.trn[0] <= buf_trn_reg[0];
                        item_reg.trn[1] <= buf_trn_reg[1];
                        item_reg.trn[2] <= buf_trn_reg[2];
                        item_reg.scl[0] <= buf_scl_reg[0];
                        item_reg.scl[1] <= buf_scl_reg[1];
                        item_reg.scl[2] <= buf_scl_reg[2];
                        item_reg.zs     <= (buf_scl_reg[0] == 32'sd0) ||
                                           (buf_scl_reg[1] == 32'sd0) ||
                                           (buf_scl_reg[2] == 32'sd0);
                        step_reg        <= 4'd0;
                        half_reg        <= 1'b0;
                        state_reg       <= F_PHASE;
                    end
                end
                F_PHASE:
                begin
                    half_reg <= !half_reg;
                    if (half_reg)
                    begin
                        ph_reg[step_reg[1:0]] <= prod_reg[47:16];
                        if (step_reg == 4'd2)
                        begin
                            step_reg  <= 4'd0;
                            ev_reg    <= 3'd0;
                            state_reg <= F_SINE;
                        end
                        else
                        begin
                            step_reg <= step_reg + 4'd1;
                        end
                    end
                end
                F_SINE:
                begin
                    half_reg <= !half_reg;
                    if (half_reg)
                    begin
                        if (step_reg == 4'd0)
                        begin
                            x2_reg   <= shr[30:0];
                            p_reg    <= horner_coef(3'd0);
                            step_reg <= step_reg + 4'd1;
                        end
                        else if (step_reg == 4'd6)
                        begin
                            sc_reg[ev_reg] <= sv;
                            step_reg       <= 4'd0;
                            if (ev_reg == C3)
                            begin
                                state_reg <= F_ROT;
                            end
                            else
                            begin
                                ev_reg <= ev_reg + 3'd1;
                            end
                        end
                        else
                        begin
                            p_reg    <= horner_coef(step_reg[2:0]) - shr[33:0];
                            step_reg <= step_reg + 4'd1;
                        end
                    end
                end
                F_ROT:
                begin
                    half_reg <= !half_reg;
                    if (half_reg)
                    begin
                        case (step_reg)
                            4'd0:  s1s2_reg <= r[31:0];
                            4'd1:  c1s2_reg <= r[31:0];
                            4'd2:  item_reg.rot[0][0] <= r;
                            4'd3:  item_reg.rot[0][0] <= $signed(item_reg.rot[0][0]) + r;
                            4'd4:  item_reg.rot[1][0] <= r;
                            4'd5:  item_reg.rot[2][0] <= r;
                            4'd6:  item_reg.rot[2][0] <= $signed(item_reg.rot[2][0]) - r;
                            4'd7:  item_reg.rot[0][1] <= r;
                            4'd8:  item_reg.rot[0][1] <= $signed(item_reg.rot[0][1]) - r;
                            4'd9:  item_reg.rot[1][1] <= r;
                            4'd10: item_reg.rot[2][1] <= r;
                            4'd11: item_reg.rot[2][1] <= $signed(item_reg.rot[2][1]) + r;
                            4'd12: item_reg.rot[0][2] <= r;
                            default:
                            begin
                                item_reg.rot[2][2] <= r;
                                item_reg.rot[1][2] <= -33'(sc_reg[S2]);
                            end
                        endcase
                        if (step_reg == 4'd13)
                        begin
                            state_reg <= F_PUSH;
                        end
                        else
                        begin
                            step_reg <= step_reg + 4'd1;
                        end
                    end
                end
                F_PUSH:
                begin
                    if (!fifo_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/estm_fifo.sv
// two-entry queue of prepared rotation terms between front and back
`default_nettype none
module estm_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  estm_pkg::item_t wr_item,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output estm_pkg::item_t head
);
    import estm_pkg::*;

    item_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == FIFO_DEPTH);
    assign empty = (cnt_reg == 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                mem_reg[wr_ptr_reg] <= wr_item;
                wr_ptr_reg          <= !wr_ptr_reg;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if ((push && !full) && !(pop && !empty))
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (!(push && !full) && (pop && !empty))
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/estm_back.sv
// back end: column sequencer over three row lanes and the result register
`default_nettype none
module estm_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fifo_empty,
    input  estm_pkg::item_t    head,
    output logic               fifo_pop,
    output logic               empty,
    input  logic               pop,
    output logic               matrix_id,
    output logic [1:0]         column_index,
    output logic signed [31:0] elem_x,
    output logic signed [31:0] elem_y,
    output logic signed [31:0] elem_z,
    output logic [16:0]        elem_w,
    output logic               zero_scale,
    output logic               last_column
);
    import estm_pkg::*;

    typedef enum logic [1:0] {B_IDLE, B_START, B_WAIT, B_EMIT} bstate_t;

    bstate_t          state_reg;
    logic [2:0]       col_reg;
    logic             out_valid_reg;
    logic             mid_reg;
    logic [1:0]       cidx_reg;
    logic [31:0]      ex_reg;
    logic [31:0]      ey_reg;
    logic [31:0]      ez_reg;
    logic [16:0]      ew_reg;
    logic             zs_reg;
    logic             last_reg;

    lane_ctl_t        ctl;
    logic [2:0]       done;
    logic [2:0][31:0] res;
    logic [1:0]       cidx;
    logic             slot_free;
    logic             is_trn;

    assign is_trn    = (col_reg == TRN_COL);
    assign cidx      = (col_reg >= NRM_COL0) ? 2'(col_reg - NRM_COL0) : col_reg[1:0];
    assign ctl.start = (state_reg == B_START) && !is_trn;
    assign ctl.normal = (col_reg >= NRM_COL0);
    assign slot_free = !out_valid_reg || pop;
    assign fifo_pop  = (state_reg == B_EMIT) && slot_free && (col_reg == LAST_COL);

    for (genvar row = 0; row < 3; row++)
    begin : g_lane
        estm_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (ctl),
            .term   (head.rot[row][cidx]),
            .scale  (head.scl[cidx]),
            .done   (done[row]),
            .result (res[row])
        );
    end

    assign empty        = !out_valid_reg;
    assign matrix_id    = mid_reg;
    assign column_index = cidx_reg;
    assign elem_x       = ex_reg;
    assign elem_y       = ey_reg;
    assign elem_z       = ez_reg;
    assign elem_w       = ew_reg;
    assign zero_scale   = zs_reg;
    assign last_column  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            col_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && out_valid_reg && !((state_reg == B_EMIT) && slot_free))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (!fifo_empty)
                    begin
                        col_reg   <= 3'd0;
                        state_reg <= B_START;
                    end
                end
                B_START:
                begin
                    state_reg <= is_trn ? B_EMIT : B_WAIT;
                end
                B_WAIT:
                begin
                    if (&done)
                    begin
                        state_reg <= B_EMIT;
                    end
                end
                B_EMIT:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        mid_reg       <= (col_reg >= NRM_COL0);
                        cidx_reg      <= cidx;
                        ex_reg        <= is_trn ? head.trn[0] : res[0];
                        ey_reg        <= is_trn ? head.trn[1] : res[1];
                        ez_reg        <= is_trn ? head.trn[2] : res[2];
                        ew_reg        <= is_trn ? W_ONE : 17'd0;
                        zs_reg        <= head.zs;
                        last_reg      <= (col_reg == LAST_COL);
                        if (col_reg == LAST_COL)
                        begin
                            state_reg <= B_IDLE;
                        end
                        else
                        begin
                            col_reg   <= col_reg + 3'd1;
                            state_reg <= B_START;
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
